// ----- hw/rtl/linear_probing_hash_table_assert.svh -----
// Assertion macros shared by the hash table RTL.
// No dependencies; the including module supplies clock, reset and signals.
`ifndef LINEAR_PROBING_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBING_HASH_TABLE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPHT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LPHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/lpht_pkg.sv -----
// Types and constants of the linear probing hash table.
// No dependencies.
package lpht_pkg;

    localparam int KEY_W  = 31;
    localparam int VAL_W  = 32;
    localparam int ACT_W  = 2;
    localparam int STAT_W = 2;

    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 32;
    localparam int M_USER_W = 1 + STAT_W;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_slot;

endpackage

// ----- hw/rtl/linear_probing_hash_table.sv -----
// Linear probing hash table: top level with slot memory and probe sequencer.
// Depends on lpht_pkg and linear_probing_hash_table_assert.svh.
//
//  Channel   Dir  Beat fields (tdata / tuser)
//  s_axis    in   tdata: key[30:0], value[62:31]   tuser: action[1:0]
//  m_axis    out  tdata: read_value[31:0]          tuser: found[0], status[2:1]
//
// A request passes through the hash state (reciprocal multiply) and fold state
// (remainder fold) when TABLE_SIZE is not a power of two, then a read and a
// compare state per slot probed (1 to TABLE_SIZE); an unused action code goes
// straight to the response state. Each probe is one read and one compare on
// the single memory port. After reset a clearing pass empties the table; the
// input is not ready during it. A result that finds the previous beat still
// waiting holds the block in its response state until that beat is taken.
`include "linear_probing_hash_table_assert.svh"

module linear_probing_hash_table
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,   // key[30:0], value[62:31], zero pad
    input  logic [ACT_W-1:0]    i_s_axis_tuser,   // action[1:0]
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [M_DATA_W-1:0] o_m_axis_tdata,   // read_value[31:0]
    output logic [M_USER_W-1:0] o_m_axis_tuser    // found[0], status[2:1]
);

    localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam bit IS_POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
    localparam logic [IDX_W-1:0] SIZE_LOW = IDX_W'(TABLE_SIZE);
    localparam int RECIP_W   = 32;
    localparam int QUO_SHIFT = KEY_W + IDX_W;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << QUO_SHIFT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_FOLD,
        S_READ,
        S_CMP,
        S_RESP
    } t_state;

    t_state                      r_state;
    logic [ACT_W-1:0]            r_action;
    logic [KEY_W-1:0]            r_key;
    logic [VAL_W-1:0]            r_value;
    logic [IDX_W-1:0]            r_pos;
    logic [IDX_W-1:0]            r_cnt;
    logic [KEY_W+RECIP_W-1:0]    r_prod;
    logic                        r_res_found;
    logic [STAT_W-1:0]           r_res_status;
    logic [VAL_W-1:0]            r_res_data;
    logic                        r_ovalid;
    logic [M_DATA_W-1:0]         r_odata;
    logic [M_USER_W-1:0]         r_ouser;

    t_slot               r_mem [TABLE_SIZE];
    t_slot               r_rd;

    logic                w_s_fire;
    logic                w_m_fire;
    logic                w_empty;
    logic                w_hit;
    logic                w_mem_we;
    t_slot               w_mem_wdata;
    logic [IDX_W-1:0]    n_pos;

    assign w_s_fire = i_s_axis_tvalid && o_s_axis_tready;
    assign w_m_fire = r_ovalid && i_m_axis_tready;

    assign w_empty = !r_rd.valid;
    assign w_hit   = r_rd.valid && (r_rd.key == r_key);

    assign n_pos = (r_pos == LAST_IDX) ? '0 : r_pos + 1'b1;

    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                w_mem_we = 1'b1;
            end
            S_CMP: begin
                if (r_action == ACT_INSERT) begin
                    w_mem_we    = w_empty || w_hit;
                    w_mem_wdata = '{valid: 1'b1, key: r_key, value: r_value};
                end else if (r_action == ACT_REMOVE) begin
                    w_mem_we = w_hit;
                end
            end
            default: begin
                w_mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_pos] <= w_mem_wdata;
        end
        r_rd <= r_mem[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_pos    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // In the response state the output register is reloaded instead.
            if (w_m_fire && (r_state != S_RESP)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_pos <= n_pos;
                    if (r_pos == LAST_IDX) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_s_fire) begin
                        r_action     <= i_s_axis_tuser;
                        r_key        <= i_s_axis_tdata[KEY_W-1:0];
                        r_value      <= i_s_axis_tdata[KEY_W +: VAL_W];
                        r_cnt        <= '0;
                        r_res_found  <= 1'b0;
                        r_res_status <= ST_DONE;
                        r_res_data   <= '0;
                        if (i_s_axis_tuser != ACT_INSERT && i_s_axis_tuser != ACT_SEARCH &&
                            i_s_axis_tuser != ACT_REMOVE) begin
                            r_state <= S_RESP;
                        end else if (IS_POW2) begin
                            r_pos   <= i_s_axis_tdata[IDX_W-1:0];
                            r_state <= S_READ;
                        end else begin
                            r_state <= S_HASH;
                        end
                    end
                end
                S_HASH: begin
                    // The quotient key / TABLE_SIZE is this product shifted right.
                    r_prod  <= r_key * RECIP;
                    r_state <= S_FOLD;
                end
                S_FOLD: begin
                    // The remainder fits the index, so only the low bits are needed.
                    r_pos   <= r_key[IDX_W-1:0] - r_prod[QUO_SHIFT +: IDX_W] * SIZE_LOW;
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (w_empty) begin
                        if (r_action != ACT_INSERT) begin
                            r_res_status <= ST_MISS;
                        end
                        r_state <= S_RESP;
                    end else if (w_hit) begin
                        r_res_found <= 1'b1;
                        if (r_action == ACT_SEARCH) begin
                            r_res_data <= r_rd.value;
                        end
                        r_state <= S_RESP;
                    end else if (r_cnt == LAST_IDX) begin
                        // A full pass met neither the key nor an empty slot.
                        r_res_status <= (r_action == ACT_INSERT) ? ST_FULL : ST_MISS;
                        r_state      <= S_RESP;
                    end else begin
                        r_pos   <= n_pos;
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_RESP: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= r_res_data;
                        r_ouser  <= {r_res_status, r_res_found};
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;

    `LPHT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_s_fire, !o_s_axis_tready,
        "input still ready in the cycle after a request was accepted")
    `LPHT_ASSERT_NOW(a_write_states, i_clk, i_rst_n, w_mem_we,
        (r_state == S_CLEAR) || (r_state == S_CMP), "slot write outside clear or compare")
    `LPHT_ASSERT_NOW(a_data_needs_found, i_clk, i_rst_n,
        o_m_axis_tvalid && (o_m_axis_tdata != '0), o_m_axis_tuser[0],
        "nonzero read value on a result without a hit")
    `LPHT_ASSERT_NOW(a_full_only_insert, i_clk, i_rst_n,
        (r_state == S_RESP) && (r_res_status == ST_FULL), r_action == ACT_INSERT,
        "table full reported for a request other than insert")

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the linear probing hash table.
// Depends on lpht_pkg and the linear_probing_hash_table top level; it keeps its
// own copy of the slot table to predict each response beat that a directed row does not spell out.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lpht_pkg::*;

    localparam int TABLE_SIZE     = 256;
    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 7;
    localparam int RANDOM_ITEMS   = 480;
    localparam int POOL_SIZE      = 24;
    localparam int FULL_TABLE_OPS = 24;
    localparam int DRAIN_CYCLES   = 2 * TABLE_SIZE + 16;
    localparam int CYCLE_LIMIT    = 6_000_000;

    // The package names no code for the fourth action value.
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_lpht_req;

    typedef struct packed {
        logic              found;
        logic [VAL_W-1:0]  read_value;
        logic [STAT_W-1:0] status;
    } t_lpht_resp;

    typedef struct {
        t_lpht_req  req;
        bit         typed;
        t_lpht_resp resp;
    } t_directed_row;

    logic                i_clk;
    logic                i_rst_n         = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [S_DATA_W-1:0] i_s_axis_tdata  = '0;  // key[30:0], value[62:31], zero pad
    logic [ACT_W-1:0]    i_s_axis_tuser  = '0;  // action[1:0]
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] o_m_axis_tdata;        // read_value[31:0]
    logic [M_USER_W-1:0] o_m_axis_tuser;        // found[0], status[2:1]

    // Shadow copy of the slot table.
    bit               ht_valid [TABLE_SIZE];
    logic [KEY_W-1:0] ht_key   [TABLE_SIZE];
    logic [VAL_W-1:0] ht_value [TABLE_SIZE];

    t_lpht_resp       pending_responses[$];
    t_directed_row    directed_rows[$];
    logic [KEY_W-1:0] key_pool[POOL_SIZE];
    logic [KEY_W-1:0] fill_keys[$];

    int gap_pct     = 34;
    int stall_pct   = 78;
    int error_count = 0;
    int cycle_count = 0;

    linear_probing_hash_table u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Applies one request to the shadow table and returns the response it causes.
    function automatic t_lpht_resp update_table(input t_lpht_req rq);
        t_lpht_resp  rs;
        int unsigned idx;
        int          n;
        bit          hit;
        bit          has_free;
        rs       = '{found: 1'b0, read_value: '0, status: ST_DONE};
        hit      = 1'b0;
        has_free = 1'b0;
        idx      = rq.key % TABLE_SIZE;
        for (n = 0; n < TABLE_SIZE; n++) begin
            if (!ht_valid[idx]) begin
                has_free = 1'b1;
                break;
            end
            if (ht_key[idx] == rq.key) begin
                hit = 1'b1;
                break;
            end
            idx = (idx + 1) % TABLE_SIZE;
        end
        case (rq.action)
            ACT_INSERT: begin
                if (hit) begin
                    ht_value[idx] = rq.value;
                    rs.found      = 1'b1;
                end else if (has_free) begin
                    ht_valid[idx] = 1'b1;
                    ht_key[idx]   = rq.key;
                    ht_value[idx] = rq.value;
                end else begin
                    rs.status = ST_FULL;
                end
            end
            ACT_SEARCH: begin
                if (hit) begin
                    rs.found      = 1'b1;
                    rs.read_value = ht_value[idx];
                end else begin
                    rs.status = ST_MISS;
                end
            end
            ACT_REMOVE: begin
                if (hit) begin
                    rs.found      = 1'b1;
                    ht_valid[idx] = 1'b0;
                end else begin
                    rs.status = ST_MISS;
                end
            end
            default: begin
            end
        endcase
        return rs;
    endfunction

    function automatic int occupied_slots();
        int cnt;
        cnt = 0;
        for (int s = 0; s < TABLE_SIZE; s++) cnt += ht_valid[s];
        return cnt;
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Most pool keys share home slots around the wrap point so that chains
    // collide and cross from the last slot to slot 0.
    task automatic refresh_key_pool();
        logic [31:0] k;
        int unsigned home;
        for (int p = 0; p < POOL_SIZE; p++) begin
            k = $urandom & 32'h7FFF_FFFF;
            if (p % 4 != 3) begin
                home = (TABLE_SIZE - 6 + $urandom_range(0, 11)) % TABLE_SIZE;
                k    = k - (k % TABLE_SIZE) + home;
            end
            key_pool[p] = k[KEY_W-1:0];
        end
    endtask

    function automatic t_lpht_req random_request();
        t_lpht_req   rq;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)      rq.action = ACT_INSERT;
        else if (r < 75) rq.action = ACT_SEARCH;
        else if (r < 95) rq.action = ACT_REMOVE;
        else             rq.action = ACT_UNUSED;
        if ($urandom_range(0, 99) < 80) rq.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else                            rq.key = KEY_W'($urandom);
        rq.value = pick_value();
        return rq;
    endfunction

    // Presents one request beat and waits for it to be taken.
    task automatic send_request(input t_lpht_req rq, input bit typed,
                                input t_lpht_resp typed_resp);
        t_lpht_resp model_resp;
        if ($urandom_range(0, 99) < gap_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < gap_pct);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, rq.value, rq.key};
        i_s_axis_tuser  <= rq.action;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        model_resp = update_table(rq);
        pending_responses.push_back(typed ? typed_resp : model_resp);
    endtask

    task automatic add_row(input logic [ACT_W-1:0] action, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] value, input bit typed,
                           input logic found, input logic [VAL_W-1:0] read_value,
                           input logic [STAT_W-1:0] status);
        t_directed_row row;
        row.req   = '{action: action, key: key, value: value};
        row.typed = typed;
        row.resp  = '{found: found, read_value: read_value, status: status};
        directed_rows.push_back(row);
    endtask

    always @(posedge i_clk) begin : response_check
        t_lpht_resp want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_responses.size() == 0) begin
                $error("response beat with no request outstanding");
                error_count++;
            end else begin
                want = pending_responses.pop_front();
                if (o_m_axis_tuser[0] !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, o_m_axis_tuser[0]);
                    error_count++;
                end
                if (o_m_axis_tdata !== want.read_value) begin
                    $error("read_value: expected %h, got %h", want.read_value,
                           o_m_axis_tdata);
                    error_count++;
                end
                if (o_m_axis_tuser[2:1] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status,
                           o_m_axis_tuser[2:1]);
                    error_count++;
                end
            end
        end
    end

    initial begin
        t_lpht_req  rq;
        t_lpht_resp no_resp;
        int         n;
        no_resp = '0;
        for (int s = 0; s < TABLE_SIZE; s++) begin
            ht_valid[s] = 1'b0;
            ht_key[s]   = '0;
            ht_value[s] = '0;
        end

        // Keys 0, 255, 256, 511 and 7FFFFFFF all start in slot 255 or slot 0,
        // so these rows exercise wraparound and the holes left by a remove.
        add_row(ACT_SEARCH, 31'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0, ST_MISS);
        add_row(ACT_REMOVE, 31'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0, ST_MISS);
        add_row(ACT_UNUSED, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, ST_DONE);
        add_row(ACT_INSERT, 31'h0000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0, ST_DONE);
        add_row(ACT_SEARCH, 31'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF,
                ST_DONE);
        add_row(ACT_INSERT, 31'h0000_0000, 32'h8000_0000, 1'b1, 1'b1, 32'h0, ST_DONE);
        add_row(ACT_SEARCH, 31'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h8000_0000,
                ST_DONE);
        add_row(ACT_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, ST_DONE);
        add_row(ACT_INSERT, 31'h0000_00FF, 32'h1234_5678, 1'b0, 1'b0, 32'h0, ST_DONE);
        add_row(ACT_SEARCH, 31'h0000_00FF, 32'h0000_0000, 1'b0, 1'b0, 32'h0, ST_DONE);
        add_row(ACT_INSERT, 31'h0000_0100, 32'h0000_0000, 1'b0, 1'b0, 32'h0, ST_DONE);
        add_row(ACT_INSERT, 31'h0000_01FF, 32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0, ST_DONE);
        add_row(ACT_REMOVE, 31'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0, ST_DONE);
        add_row(ACT_SEARCH, 31'h0000_0100, 32'h0000_0000, 1'b0, 1'b0, 32'h0, ST_DONE);
        add_row(ACT_SEARCH, 31'h0000_01FF, 32'h0000_0000, 1'b0, 1'b0, 32'h0, ST_DONE);
        add_row(ACT_REMOVE, 31'h0000_00FF, 32'h0000_0000, 1'b0, 1'b0, 32'h0, ST_DONE);
        add_row(ACT_INSERT, 31'h0000_00FF, 32'h5555_5555, 1'b0, 1'b0, 32'h0, ST_DONE);
        add_row(ACT_SEARCH, 31'h0000_00FF, 32'h0000_0000, 1'b0, 1'b0, 32'h0, ST_DONE);
        add_row(ACT_REMOVE, 31'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h0, ST_DONE);
        add_row(ACT_SEARCH, 31'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0, ST_MISS);
        add_row(ACT_UNUSED, 31'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0, ST_DONE);
        add_row(ACT_SEARCH, 31'h2AAA_AAAA, 32'h5555_5555, 1'b1, 1'b0, 32'h0, ST_MISS);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            send_request(directed_rows[r].req, directed_rows[r].typed, directed_rows[r].resp);
        end

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin gap_pct = 34; stall_pct = 78; end
                1: begin gap_pct = 78; stall_pct = 34; end
                default: begin gap_pct = 0; stall_pct = 0; end
            endcase
            refresh_key_pool();
            for (n = 0; n < RANDOM_ITEMS; n++) begin
                send_request(random_request(), 1'b0, no_resp);
            end

            if (phase == 0) begin
                // Fill every slot with fresh keys, work on the full table, then
                // remove the fill keys newest first, which restores the table.
                fill_keys.delete();
                while (occupied_slots() < TABLE_SIZE) begin
                    rq = '{action: ACT_INSERT, key: KEY_W'($urandom), value: pick_value()};
                    fill_keys.push_back(rq.key);
                    send_request(rq, 1'b0, no_resp);
                end
                for (n = 0; n < FULL_TABLE_OPS; n++) begin
                    rq.value = pick_value();
                    case (n % 4)
                        0: begin rq.action = ACT_INSERT; rq.key = KEY_W'($urandom); end
                        1: begin rq.action = ACT_SEARCH; rq.key = KEY_W'($urandom); end
                        2: begin
                            rq.action = ACT_INSERT;
                            rq.key    = fill_keys[$urandom_range(0, fill_keys.size() - 1)];
                        end
                        default: begin
                            rq.action = ACT_SEARCH;
                            rq.key    = fill_keys[$urandom_range(0, fill_keys.size() - 1)];
                        end
                    endcase
                    send_request(rq, 1'b0, no_resp);
                end
                for (n = fill_keys.size() - 1; n >= 0; n--) begin
                    rq = '{action: ACT_REMOVE, key: fill_keys[n], value: pick_value()};
                    send_request(rq, 1'b0, no_resp);
                end
            end
        end

        i_s_axis_tvalid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && pending_responses.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/lpht_pkg.sv
hw/rtl/linear_probing_hash_table.sv
tb/tb.sv
